// ----- src/fqrr_pkg.sv -----
`default_nettype none

package fqrr_pkg;

	// Number of approach sides and the width of a side number.
	localparam int SIDE_COUNT = 4;
	localparam int SIDE_W = 2;

	// Identifier width and the default depth of each queue.
	localparam int ID_W = 10;
	localparam int QUEUE_DEPTH_DEF = 64;

	// Operation codes on the input stream.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;

	// Status codes on the result stream.
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	// Outcome of the round-robin search.
	typedef struct packed {
		logic found;
		logic [SIDE_W-1:0] side;
	} pick_t;

endpackage

`default_nettype wire

// ----- src/fqrr_pick.sv -----
`default_nettype none

// Round-robin search: first non-empty side at or after the start side.
module fqrr_pick (
	input  logic [fqrr_pkg::SIDE_COUNT-1:0] nonempty,
	input  logic [fqrr_pkg::SIDE_W-1:0]     start,
	output fqrr_pkg::pick_t                 pick
);

	localparam int SW = fqrr_pkg::SIDE_W;

	always_comb begin
		logic [SW-1:0] s;
		pick = '0;
		s = '0;
		// Walk from the farthest candidate back to the start so the nearest wins.
		for (int k = fqrr_pkg::SIDE_COUNT - 1; k >= 0; k--) begin
			s = start + SW'(k);
			if (nonempty[s]) begin
				pick.found = 1'b1;
				pick.side = s;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/fqrr_store.sv -----
`default_nettype none

// Identifier storage for all four queues, one write and one read port.
module fqrr_store #(
	parameter int QUEUE_DEPTH = fqrr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [fqrr_pkg::SIDE_W-1:0]                  wr_side,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]               wr_ptr,
	input  logic [fqrr_pkg::ID_W-1:0]                    wr_data,
	input  logic                                         rd_en,
	input  logic [fqrr_pkg::SIDE_W-1:0]                  rd_side,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]               rd_ptr,
	output logic [fqrr_pkg::ID_W-1:0]                    rd_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int ENTRIES = fqrr_pkg::SIDE_COUNT << PTR_W;

	logic [fqrr_pkg::ID_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{wr_side, wr_ptr}] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[{rd_side, rd_ptr}];
		end
	end

endmodule

`default_nettype wire

// ----- src/four_queue_round_robin_merge.sv -----
`default_nettype none

// Channel   Direction  Width  Contents
// s_*       in         16     one push or pop request per transfer
// m_*       out        16     one status result per request, in request order
//
// One request is taken every cycle when the result side keeps up.
// The request is registered, then decided against the queue pointers while
// the queue memory is written or read, and the result is registered together
// with the registered read port that supplies the served identifier.
// The asynchronous reset empties all queues and restarts the search at west;
// the memory contents are left as they are and are never read before written.
// When m_tready is low with a result waiting, both stages hold and s_tready
// drops once the request register is occupied.
module four_queue_round_robin_merge #(
	parameter int QUEUE_DEPTH = fqrr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [0] operation, [2:1] side, [12:3] craft_id, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] status, [11:2] served_id, [13:12] served_side
);

	localparam int SW = fqrr_pkg::SIDE_W;
	localparam int NS = fqrr_pkg::SIDE_COUNT;
	localparam int IW = fqrr_pkg::ID_W;
	localparam int STW = fqrr_pkg::STATUS_W;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Stage one: the accepted request.
	logic          valid_s1;
	logic          op_s1;
	logic [SW-1:0] side_s1;
	logic [IW-1:0] id_s1;

	// Stage two: the decided result; the served identifier comes from the memory.
	logic           valid_s2;
	logic [STW-1:0] status_s2;
	logic [SW-1:0]  side_s2;
	logic [IW-1:0]  rd_data;

	// Queue bookkeeping. The tail pointer stands in for head plus count.
	logic [PTR_W-1:0] head_q  [NS];
	logic [PTR_W-1:0] tail_q  [NS];
	logic [CNT_W-1:0] count_q [NS];
	logic [SW-1:0]    next_side_q;

	logic              s1_advance;
	logic              s_accept;
	logic [NS-1:0]     nonempty;
	fqrr_pkg::pick_t   pick;
	logic              full;
	logic              do_write;
	logic              do_read;
	logic [STW-1:0]    status_next;
	logic [SW-1:0]     side_next;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Both stages move together whenever the result register can be refilled.
	assign s1_advance = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || s1_advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1 <= s_tdata[0];
			side_s1 <= s_tdata[SW:1];
			id_s1 <= s_tdata[SW+IW:SW+1];
		end
	end

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			nonempty[i] = (count_q[i] != '0);
		end
	end

	fqrr_pick u_pick (
		.nonempty (nonempty),
		.start    (next_side_q),
		.pick     (pick)
	);

	assign full = (count_q[side_s1] == CNT_W'(QUEUE_DEPTH));
	assign do_write = s1_advance && (op_s1 == fqrr_pkg::OP_PUSH) && !full;
	assign do_read = s1_advance && (op_s1 == fqrr_pkg::OP_POP) && pick.found;

	always_comb begin
		status_next = fqrr_pkg::ST_PUSHED;
		side_next = '0;
		if (op_s1 == fqrr_pkg::OP_PUSH) begin
			status_next = full ? fqrr_pkg::ST_FULL : fqrr_pkg::ST_PUSHED;
		end else if (pick.found) begin
			status_next = fqrr_pkg::ST_POPPED;
			side_next = pick.side;
		end else begin
			status_next = fqrr_pkg::ST_EMPTY;
		end
	end

	// Pointer and occupancy updates; a single request touches at most one side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				count_q[i] <= '0;
			end
			next_side_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (do_write && (side_s1 == SW'(i))) begin
					tail_q[i] <= ptr_next(tail_q[i]);
					count_q[i] <= count_q[i] + 1'b1;
				end
				if (do_read && (pick.side == SW'(i))) begin
					head_q[i] <= ptr_next(head_q[i]);
					count_q[i] <= count_q[i] - 1'b1;
				end
			end
			if (do_read) begin
				next_side_q <= pick.side + 1'b1;
			end
		end
	end

	fqrr_store #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_side (side_s1),
		.wr_ptr  (tail_q[side_s1]),
		.wr_data (id_s1),
		.rd_en   (do_read),
		.rd_side (pick.side),
		.rd_ptr  (head_q[pick.side]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			status_s2 <= status_next;
			side_s2 <= side_next;
		end
	end

	// The memory read data is fresh only for a successful pop; otherwise report zero.
	assign m_tvalid = valid_s2;
	assign m_tdata = {2'b00, side_s2,
		(status_s2 == fqrr_pkg::ST_POPPED) ? rd_data : {IW{1'b0}}, status_s2};

	for (genvar g = 0; g < NS; g++) begin : g_chk
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= CNT_W'(QUEUE_DEPTH))
			else $error("queue occupancy beyond depth");
		a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
			head_q[g] <= PTR_W'(QUEUE_DEPTH - 1))
			else $error("head pointer outside queue");
	end

	a_rr_advance: assert property (@(posedge clk) disable iff (!arst_n)
		do_read |=> next_side_q == $past(pick.side) + 1'b1)
		else $error("search start did not move past the served side");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> count_q[$past(side_s1)] != '0)
		else $error("queue still empty after a push");

endmodule

`default_nettype wire

// ----- verif/merge_order_checker.sv -----
`default_nettype none

// Watches both streams of the merge block. Every request transfer is run
// through a local model of the four side queues and the round-robin pointer,
// and the outcome it should produce is queued. Every result transfer is
// compared, field by field, with the oldest queued outcome.
module merge_order_checker
	import fqrr_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // [0] operation, [2:1] side, [12:3] craft_id, rest zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // [1:0] status, [11:2] served_id, [13:12] served_side
	output int          fail_count,
	output int          outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic [SIDE_W-1:0]   side;
	} outcome_t;

	outcome_t          pending_outcomes[$];
	logic [ID_W-1:0]   lane_slots[SIDE_COUNT][QUEUE_DEPTH];
	int                lane_head[SIDE_COUNT];
	int                lane_fill[SIDE_COUNT];
	logic [SIDE_W-1:0] rr_start;

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	// Applies one request to the local queues and returns its outcome.
	function automatic outcome_t serve_request(input logic [15:0] word);
		logic              op;
		logic [SIDE_W-1:0] sd;
		logic [ID_W-1:0]   id;
		logic [SIDE_W-1:0] s;
		outcome_t          r;
		op = word[0];
		sd = word[2:1];
		id = word[12:3];
		r = '0;
		if (op == OP_PUSH) begin
			if (lane_fill[sd] >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				lane_slots[sd][(lane_head[sd] + lane_fill[sd]) % QUEUE_DEPTH] = id;
				lane_fill[sd]++;
				r.status = ST_PUSHED;
			end
			return r;
		end
		// Search starts at the side after the one served last and wraps.
		r.status = ST_EMPTY;
		for (int k = 0; k < SIDE_COUNT; k++) begin
			s = rr_start + SIDE_W'(k);
			if (r.status == ST_EMPTY && lane_fill[s] != 0) begin
				r.status = ST_POPPED;
				r.id = lane_slots[s][lane_head[s]];
				r.side = s;
				lane_head[s] = (lane_head[s] + 1) % QUEUE_DEPTH;
				lane_fill[s]--;
				rr_start = s + 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			pending_outcomes.delete();
			for (int k = 0; k < SIDE_COUNT; k++) begin
				lane_head[k] = 0;
				lane_fill[k] = 0;
			end
			rr_start = '0;
			outstanding = 0;
		end else begin
			// A result never leaves at the edge that takes its request, so the result
			// side is handled before this edge's request is predicted.
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.id = m_tdata[11:2];
				got.side = m_tdata[13:12];
				if (pending_outcomes.size() == 0) begin
					report_mismatch($sformatf("result 0x%h with no request waiting",
						m_tdata));
				end else begin
					want = pending_outcomes.pop_front();
					if (got.status != want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							got.status, want.status));
					if (got.id != want.id)
						report_mismatch($sformatf("served_id %0d, expected %0d",
							got.id, want.id));
					if (got.side != want.side)
						report_mismatch($sformatf("served_side %0d, expected %0d",
							got.side, want.side));
				end
			end
			if (s_tvalid && s_tready)
				pending_outcomes.push_back(serve_request(s_tdata));
			outstanding = pending_outcomes.size();
		end
	end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

// Top of the testbench for the four-queue round-robin merge. This module only
// makes stimulus and gives the verdict; the checker instance beside the block
// predicts every result and counts mismatches.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import fqrr_pkg::*;

	// Side numbers as the request stream encodes them.
	localparam logic [SIDE_W-1:0] SIDE_WEST = 2'd0;
	localparam logic [SIDE_W-1:0] SIDE_NORTH = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_SOUTH = 2'd2;
	localparam logic [SIDE_W-1:0] SIDE_EAST = 2'd3;

	// Number of random requests, and the window of them run with no idling.
	localparam int RANDOM_ITEMS = 800;
	localparam int STEADY_FIRST = 300;
	localparam int STEADY_LAST = 450;
	// A very loose bound: even with long idles on both sides a correct run
	// needs well under a tenth of this.
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PERCENT = 28;

	// Traffic mix of one random block. Filling blocks mostly push to one side's
	// queue, draining blocks mostly pop, mixed blocks interleave both.
	typedef enum logic [1:0] {
		TRAFFIC_FILL,
		TRAFFIC_DRAIN,
		TRAFFIC_MIX
	} traffic_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [0] operation, [2:1] side, [12:3] craft_id, rest zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // [1:0] status, [11:2] served_id, [13:12] served_side

	// While set, neither side idles.
	logic steady = 1'b0;
	int   cycles = 0;
	int   fail_count;
	int   outstanding;

	four_queue_round_robin_merge #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	merge_order_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The result side stalls at random, except during the steady window.
	// Inputs only change at the falling edge, half a cycle away from the
	// rising edge where the block and the checker sample them.
	initial begin
		forever begin
			@(negedge clk);
			m_tready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one request and returns at the falling edge after its transfer.
	// It is entered at a falling edge. Random idle cycles come first, so gaps
	// land between any two requests.
	task automatic put_request(input logic op, input logic [SIDE_W-1:0] sd,
			input logic [ID_W-1:0] id);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {3'b000, id, sd, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Identifiers lean toward the two extremes now and then.
	function automatic logic [ID_W-1:0] pick_id();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return ID_W'($urandom_range(0, (1 << ID_W) - 1));
		endcase
	endfunction

	initial begin : stimulus
		traffic_t          mode;
		int                left;
		int                n;
		int                push_pct;
		logic              op;
		logic [SIDE_W-1:0] sd;
		logic [SIDE_W-1:0] focus;

		// Reset is asserted from the start and released once, at a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. A pop on an empty block comes first; the side and
		// identifier of a pop are set to nonzero values that must be ignored.
		put_request(OP_POP, SIDE_EAST, 10'h3FF);
		// One push to every side with extreme and alternating-bit identifiers, then a second
		// item on west and on east.
		put_request(OP_PUSH, SIDE_WEST, 10'h000);
		put_request(OP_PUSH, SIDE_NORTH, 10'h3FF);
		put_request(OP_PUSH, SIDE_SOUTH, 10'h155);
		put_request(OP_PUSH, SIDE_EAST, 10'h2AA);
		put_request(OP_PUSH, SIDE_WEST, 10'h3FF);
		put_request(OP_PUSH, SIDE_EAST, 10'h000);
		// Round-by-round drain: west, north, south, east, then west again and
		// a skip over the empty north and south queues to east.
		put_request(OP_POP, SIDE_SOUTH, 10'h3FF);
		put_request(OP_POP, SIDE_WEST, 10'h000);
		put_request(OP_POP, SIDE_NORTH, 10'h155);
		put_request(OP_POP, SIDE_EAST, 10'h2AA);
		put_request(OP_POP, SIDE_WEST, 10'h001);
		put_request(OP_POP, SIDE_WEST, 10'h200);
		// All empty again: the pointer must stay where it is.
		put_request(OP_POP, SIDE_NORTH, 10'h0F0);
		put_request(OP_PUSH, SIDE_NORTH, 10'h005);
		put_request(OP_POP, SIDE_EAST, 10'h000);
		// The search must wrap from the east end back to west.
		put_request(OP_PUSH, SIDE_WEST, 10'h007);
		put_request(OP_PUSH, SIDE_WEST, 10'h008);
		put_request(OP_POP, SIDE_WEST, 10'h000);
		put_request(OP_POP, SIDE_WEST, 10'h000);
		put_request(OP_POP, SIDE_SOUTH, 10'h3FF);

		// Random part. It opens by overfilling the east queue so that dropped
		// pushes are seen early, then runs blocks of random length and mix.
		n = 0;
		for (int k = 0; k < QUEUE_DEPTH_DEF + 6; k++) begin
			put_request(OP_PUSH, SIDE_EAST, pick_id());
			n++;
		end
		while (n < RANDOM_ITEMS) begin
			mode = traffic_t'($urandom_range(0, 2));
			left = $urandom_range(20, 120);
			focus = SIDE_W'($urandom_range(0, SIDE_COUNT - 1));
			case (mode)
				TRAFFIC_FILL: push_pct = 90;
				TRAFFIC_DRAIN: push_pct = 15;
				default: push_pct = 50;
			endcase
			while (left > 0 && n < RANDOM_ITEMS) begin
				steady = (n >= STEADY_FIRST && n < STEADY_LAST);
				op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
				sd = SIDE_W'($urandom_range(0, SIDE_COUNT - 1));
				if (mode == TRAFFIC_FILL && op == OP_PUSH && $urandom_range(0, 99) < 85)
					sd = focus;
				put_request(op, sd, pick_id());
				n++;
				left--;
			end
		end
		steady = 1'b0;
		s_tvalid = 1'b0;

		// Let every predicted result come out, then let the two-stage pipeline run on
		// with no requests so that any surplus result shows.
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
